/* hw/rtl/ldf_pkg.sv */
// Shared types and constants for the length-prefixed value deframer.
package ldf_pkg;

    // Parse phase of the front end
    typedef enum logic [1:0] {
        PH_COUNT   = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    // Result kind codes on the output tuser
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Decode queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Output tdata width: index, length, byte, status, total, padded to bytes
    localparam int ODATA_W = 112;

    // One queued record: the results caused by one input byte
    typedef struct packed {
        logic        main_vld;    // header or payload result present
        logic        main_pay;    // 1 payload byte, 0 header
        logic [31:0] index;       // value index
        logic [31:0] arg;         // header length, or payload byte in [7:0]
        logic        stat_vld;    // status result follows
        logic        stat_bad;    // invalid framing
        logic [31:0] total;       // declared value count
    } t_rec;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* hw/rtl/length_prefixed_value_deframer.sv */
// Top level: length-prefixed value deframer, byte in, results out.
// Each result is registered in the record queue and then in the back end's
// held record before tvalid rises for it.
// Throughput: one byte per cycle while the record queue is not full; a byte
// causing two results (a header or payload byte that is also the final
// byte) takes two output transfers, absorbed by the four-entry record queue.
// Reset: synchronous active-low i_rst_n clears parser state and queue.
module length_prefixed_value_deframer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [31:0] value_index, [63:32] value_length, [71:64] payload_byte,
    // [72] status, [104:73] total_values, [111:105] zero
    output logic [ldf_pkg::ODATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                   m_axis_tuser,  // [1:0] kind
    output logic                         m_axis_tlast
);
    import ldf_pkg::*;

    t_rec    w_push_rec;
    t_rec    w_pop_rec;
    t_q_stat w_qstat;
    logic    w_push;
    logic    w_pop;

    ldf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_rec   (w_push_rec)
    );

    ldf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_pop),
        .o_rec   (w_pop_rec),
        .o_stat  (w_qstat)
    );

    ldf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (w_pop_rec),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

    // Status always closes the run of its byte
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_STATUS)) |-> m_axis_tlast)
        else $error("status transfer without tlast");

    // Queue never written when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("record queue overflow");

    // Queue never read when empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("record queue underflow");

endmodule

/* hw/rtl/ldf_front.sv */
// Front end: byte parser; queues a record for each byte that causes results.
module ldf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    input  ldf_pkg::t_q_stat i_qstat,
    output logic           o_push,
    output ldf_pkg::t_rec  o_rec
);
    import ldf_pkg::*;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_pos,   n_pos;
    logic [31:0] r_word,  n_word;
    logic [31:0] r_vrem,  n_vrem;
    logic [31:0] r_prem,  n_prem;
    logic [31:0] r_idx,   n_idx;
    logic [31:0] r_decl,  n_decl;
    logic        r_err,   n_err;

    logic [31:0] w_word;
    logic        w_done;
    logic        w_accept;

    assign o_ready  = !i_qstat.full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && (o_rec.main_vld || o_rec.stat_vld);

    // Field gathering, little-endian
    assign w_word = r_word | ({24'd0, i_byte} << {r_pos, 3'b000});
    assign w_done = (r_pos == 2'd3);

    // Next state and record
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_word  = r_word;
        n_vrem  = r_vrem;
        n_prem  = r_prem;
        n_idx   = r_idx;
        n_decl  = r_decl;
        n_err   = r_err;
        o_rec   = '0;

        if (!r_err) begin
            case (r_phase)
                PH_COUNT: begin
                    n_pos = r_pos + 2'd1;
                    if (w_done) begin
                        n_decl  = w_word;
                        n_vrem  = w_word;
                        n_word  = '0;
                        n_idx   = '0;
                        n_phase = (w_word == 32'd0) ? PH_DONE : PH_LENGTH;
                    end else begin
                        n_word = w_word;
                    end
                end
                PH_LENGTH: begin
                    n_pos = r_pos + 2'd1;
                    if (w_done) begin
                        o_rec.main_vld = 1'b1;
                        o_rec.main_pay = 1'b0;
                        o_rec.index    = r_idx;
                        o_rec.arg      = w_word;
                        n_word         = '0;
                        n_prem         = w_word;
                        if (w_word == 32'd0) begin
                            // zero-length value: header only
                            n_idx   = r_idx + 32'd1;
                            n_vrem  = r_vrem - 32'd1;
                            n_phase = (r_vrem == 32'd1) ? PH_DONE : PH_LENGTH;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end else begin
                        n_word = w_word;
                    end
                end
                PH_PAYLOAD: begin
                    o_rec.main_vld = 1'b1;
                    o_rec.main_pay = 1'b1;
                    o_rec.index    = r_idx;
                    o_rec.arg      = {24'd0, i_byte};
                    n_prem         = r_prem - 32'd1;
                    if (r_prem == 32'd1) begin
                        n_idx   = r_idx + 32'd1;
                        n_vrem  = r_vrem - 32'd1;
                        n_phase = (r_vrem == 32'd1) ? PH_DONE : PH_LENGTH;
                    end
                end
                PH_DONE: begin
                    // trailing byte
                    n_err = 1'b1;
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
        end

        // Final byte: report status, then back to reset state
        if (i_last) begin
            o_rec.stat_vld = 1'b1;
            o_rec.stat_bad = n_err || (n_phase != PH_DONE);
            o_rec.total    = n_decl;
            n_phase        = PH_COUNT;
            n_pos          = '0;
            n_word         = '0;
            n_vrem         = '0;
            n_prem         = '0;
            n_idx          = '0;
            n_decl         = '0;
            n_err          = 1'b0;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COUNT;
            r_pos   <= '0;
            r_word  <= '0;
            r_vrem  <= '0;
            r_prem  <= '0;
            r_idx   <= '0;
            r_decl  <= '0;
            r_err   <= 1'b0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_word  <= n_word;
            r_vrem  <= n_vrem;
            r_prem  <= n_prem;
            r_idx   <= n_idx;
            r_decl  <= n_decl;
            r_err   <= n_err;
        end
    end

endmodule

/* hw/rtl/ldf_queue.sv */
// Short record queue between the parser and the result sequencer.
module ldf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ldf_pkg::t_rec    i_rec,
    input  logic             i_pop,
    output ldf_pkg::t_rec    o_rec,
    output ldf_pkg::t_q_stat o_stat
);
    import ldf_pkg::*;

    t_rec           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_rec        = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QAW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QAW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hw/rtl/ldf_back.sv */
// Back end: expands each record into one or two output transfers.
module ldf_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ldf_pkg::t_rec                i_rec,
    input  ldf_pkg::t_q_stat             i_qstat,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ldf_pkg::ODATA_W-1:0]  o_data,
    output logic [1:0]                   o_user,
    output logic                         o_last
);
    import ldf_pkg::*;

    t_rec  r_rec;
    logic  r_busy;
    logic  r_second;

    logic        w_last_res;
    logic        w_stat_now;
    logic        w_take;
    logic [31:0] w_index;
    logic [31:0] w_len;
    logic [7:0]  w_byte;
    logic        w_status;
    logic [31:0] w_total;

    // Second transfer of a record is always its status
    assign w_last_res = r_second || !(r_rec.main_vld && r_rec.stat_vld);
    assign w_stat_now = r_second || !r_rec.main_vld;
    assign w_take     = r_busy ? (i_ready && w_last_res) : 1'b1;
    assign o_pop      = w_take && !i_qstat.empty;

    // Result fields
    always_comb begin
        w_index  = '0;
        w_len    = '0;
        w_byte   = '0;
        w_status = 1'b0;
        w_total  = '0;
        if (w_stat_now) begin
            o_user   = KIND_STATUS;
            w_status = r_rec.stat_bad;
            w_total  = r_rec.total;
        end else if (r_rec.main_pay) begin
            o_user  = KIND_PAYLOAD;
            w_index = r_rec.index;
            w_byte  = r_rec.arg[7:0];
        end else begin
            o_user  = KIND_HEADER;
            w_index = r_rec.index;
            w_len   = r_rec.arg;
        end
    end

    assign o_valid = r_busy;
    assign o_last  = w_last_res;
    assign o_data  = {7'd0, w_total, w_status, w_byte, w_len, w_index};

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_second <= 1'b0;
        end else if (w_take) begin
            r_busy   <= !i_qstat.empty;
            r_second <= 1'b0;
        end else if (i_ready) begin
            r_second <= 1'b1;
        end
    end

    // Held record
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rec <= i_rec;
        end
    end

endmodule

/* bench/length_prefixed_value_deframer_tb.sv */
// Self-checking bench for the length-prefixed value deframer: buffers in, results checked.
module length_prefixed_value_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ldf_pkg::*;

    // One result as seen on the master side
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] index;
        logic [31:0] length;
        logic [7:0]  data;
        logic        status;
        logic [31:0] total;
        logic        last;
        logic [6:0]  pad;
    } t_deframe_result;

    // Tracks the parse of each buffer and holds the results still due
    class deframe_scoreboard;
        t_phase          phase;
        logic [1:0]      byte_pos;
        logic [31:0]     word;
        logic [31:0]     values_left;
        logic [31:0]     payload_left;
        logic [31:0]     value_idx;
        logic [31:0]     decl_total;
        logic            framing_err;
        t_deframe_result expected_results[$];
        int unsigned     mismatches;

        function new();
            clear_parse();
            mismatches = 0;
        endfunction

        function void clear_parse();
            phase        = PH_COUNT;
            byte_pos     = 2'd0;
            word         = 32'h0;
            values_left  = 32'h0;
            payload_left = 32'h0;
            value_idx    = 32'h0;
            decl_total   = 32'h0;
            framing_err  = 1'b0;
        endfunction

        // Little-endian field assembly; returns 1 on the fourth byte
        function bit gather_byte(logic [7:0] b);
            word = word | (32'(b) << {byte_pos, 3'b000});
            if (byte_pos == 2'd3) begin
                byte_pos = 2'd0;
                return 1'b1;
            end
            byte_pos = byte_pos + 2'd1;
            return 1'b0;
        endfunction

        function void finish_value();
            value_idx   = value_idx + 32'd1;
            values_left = values_left - 32'd1;
            phase       = (values_left == 32'h0) ? PH_DONE : PH_LENGTH;
        endfunction

        function t_deframe_result make_result(logic [1:0] kind, logic [31:0] index,
                                              logic [31:0] length, logic [7:0] data,
                                              logic status, logic [31:0] total);
            t_deframe_result r;
            r.kind   = kind;
            r.index  = index;
            r.length = length;
            r.data   = data;
            r.status = status;
            r.total  = total;
            r.last   = 1'b0;
            r.pad    = 7'h0;
            return r;
        endfunction

        function string describe(t_deframe_result r);
            return $sformatf({"kind=%0d idx=%0h len=%0h byte=%02h stat=%0d total=%0h",
                              " last=%0d pad=%0h"},
                             r.kind, r.index, r.length, r.data, r.status, r.total, r.last,
                             r.pad);
        endfunction

        // Accepted input byte: queue the results it causes
        function void note_byte(logic [7:0] b, logic eob);
            t_deframe_result run[$];
            if (!framing_err) begin
                case (phase)
                    PH_COUNT: begin
                        if (gather_byte(b)) begin
                            decl_total  = word;
                            values_left = word;
                            word        = 32'h0;
                            value_idx   = 32'h0;
                            phase       = (values_left == 32'h0) ? PH_DONE : PH_LENGTH;
                        end
                    end
                    PH_LENGTH: begin
                        if (gather_byte(b)) begin
                            payload_left = word;
                            word         = 32'h0;
                            run.push_back(make_result(KIND_HEADER, value_idx, payload_left,
                                                      8'h00, 1'b0, 32'h0));
                            if (payload_left == 32'h0)
                                finish_value();
                            else
                                phase = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        run.push_back(make_result(KIND_PAYLOAD, value_idx, 32'h0, b,
                                                  1'b0, 32'h0));
                        payload_left = payload_left - 32'd1;
                        if (payload_left == 32'h0)
                            finish_value();
                    end
                    // bytes past the last value are a framing error
                    default: framing_err = 1'b1;
                endcase
            end
            if (eob) begin
                run.push_back(make_result(KIND_STATUS, 32'h0, 32'h0, 8'h00,
                                          framing_err || (phase != PH_DONE), decl_total));
                clear_parse();
            end
            if (run.size() > 0)
                run[run.size() - 1].last = 1'b1;
            foreach (run[i])
                expected_results.push_back(run[i]);
        endfunction

        // Accepted output transfer: compare with the oldest expectation
        function void check_result(logic [ODATA_W-1:0] tdata, logic [1:0] tuser, logic tlast);
            t_deframe_result got;
            t_deframe_result want;
            got.kind   = tuser;
            got.index  = tdata[31:0];
            got.length = tdata[63:32];
            got.data   = tdata[71:64];
            got.status = tdata[72];
            got.total  = tdata[104:73];
            got.last   = tlast;
            got.pad    = tdata[111:105];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result: %s", $realtime, describe(got));
                return;
            end
            want = expected_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = 8'h00;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [ODATA_W-1:0]   m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    deframe_scoreboard sb = new();

    logic [7:0]  frame[$];
    int unsigned burst_left = 0;
    int unsigned bytes_sent = 0;
    int unsigned ready_mode = 0;
    int unsigned ready_cycle = 0;

    length_prefixed_value_deframer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: check each output transfer, stall on a pattern that changes mode
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if (ready_cycle % 48 == 0)
            ready_mode = $urandom_range(0, 4);
        ready_cycle++;
        case (ready_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (ready_cycle % 4 == 0);
            3: m_axis_tready <= ready_cycle[0];
            default: m_axis_tready <= (ready_cycle % 16 >= 12);
        endcase
    end

    // One byte transfer; the sender may idle between bursts of random length
    task automatic send_byte(input logic [7:0] b, input logic eob);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eob;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_byte(b, eob);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[i])
            send_byte(frame[i], i == frame.size() - 1);
        frame.delete();
    endtask

    function automatic void add_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            frame.push_back(w[8*i +: 8]);
    endfunction

    // Well-formed body: count, then length and payload per value
    function automatic void add_values(int unsigned count);
        int unsigned len;
        add_word(count);
        repeat (count) begin
            len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
            add_word(len);
            repeat (len)
                frame.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Stimulus
    initial begin
        int unsigned mode;
        int unsigned keep;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short buffer: final byte inside the count field
        frame.push_back(8'hFF);
        send_frame();
        // zero count
        add_word(32'h0);
        send_frame();
        // zero-length value, one-byte value, then a trailing final byte
        add_word(32'd2);
        add_word(32'd0);
        add_word(32'd1);
        frame.push_back(8'hFF);
        frame.push_back(8'h00);
        send_frame();
        // largest count and length, payload cut short
        add_word(32'hFFFF_FFFF);
        add_word(32'hFFFF_FFFF);
        frame.push_back(8'h5A);
        send_frame();

        // Random buffers, mostly well formed
        while (bytes_sent < 450) begin
            mode = $urandom_range(0, 9);
            if (mode <= 7) begin
                add_values($urandom_range(0, 4));
                if (mode == 6 && frame.size() > 1) begin
                    // truncated anywhere
                    keep  = $urandom_range(1, frame.size() - 1);
                    frame = frame[0:keep-1];
                end else if (mode == 7) begin
                    // trailing bytes
                    repeat ($urandom_range(1, 3))
                        frame.push_back(8'($urandom_range(0, 255)));
                end
            end else if (mode == 8) begin
                // noise
                repeat ($urandom_range(1, 12))
                    frame.push_back(8'($urandom_range(0, 255)));
            end else begin
                // random count and length, then up to three payload bytes
                add_word($urandom);
                add_word($urandom);
                repeat ($urandom_range(0, 3))
                    frame.push_back(8'($urandom_range(0, 255)));
            end
            send_frame();
        end

        s_axis_tvalid <= 1'b0;
        while (sb.expected_results.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ldf_pkg.sv
hw/rtl/ldf_front.sv
hw/rtl/ldf_queue.sv
hw/rtl/ldf_back.sv
hw/rtl/length_prefixed_value_deframer.sv
bench/length_prefixed_value_deframer_tb.sv
